>>> hw/rtl/cgpqs_pkg.sv
// Package for the credit-gated priority queue server.
// Holds request mode codes, result status codes and the queue cell control type.
// No dependencies.
`default_nettype none

package cgpqs_pkg;

    localparam int REFILL_BITS = 8;
    localparam logic [REFILL_BITS-1:0] REFILL_RESET = 8'd10;

    typedef enum logic [1:0] {
        MODE_ENQ_HIGH = 2'd0,
        MODE_ENQ_LOW  = 2'd1,
        MODE_REFILL   = 2'd2,
        MODE_SERVICE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_REFILLED = 3'd2,
        ST_SERVED   = 3'd3,
        ST_BLOCKED  = 3'd4,
        ST_NONE     = 3'd5
    } t_status;

    // Per-cell control: pop shifts the neighbor's value in, wr loads the pushed job.
    typedef struct packed {
        logic pop;
        logic wr;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hw/rtl/cgpqs_cell.sv
// One storage cell of a shifting job queue.
// Depends on cgpqs_pkg (t_cell_ctrl).
`default_nettype none

module cgpqs_cell #(
    parameter int WIDTH = 8
) (
    input  logic                  i_clk,
    input  cgpqs_pkg::t_cell_ctrl i_ctrl,
    input  logic [WIDTH-1:0]      i_data,
    input  logic [WIDTH-1:0]      i_next,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.pop) begin
            n_data = i_next;
        end else if (i_ctrl.wr) begin
            n_data = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> hw/rtl/cgpqs_queue.sv
// Job FIFO built as a row of cells; head sits in cell 0 and a pop shifts all toward it.
// Depends on cgpqs_pkg and cgpqs_cell.
`default_nettype none

module cgpqs_queue #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_pop,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty,
    output logic             o_full,
    output logic             o_last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [WIDTH-1:0] w_data [DEPTH+1];

    assign w_data[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cgpqs_pkg::t_cell_ctrl w_ctrl;

        assign w_ctrl.pop = i_pop;
        assign w_ctrl.wr  = i_push && (r_count == CW'(g));

        cgpqs_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_data (i_data),
            .i_next (w_data[g+1]),
            .o_data (w_data[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_push) begin
            n_count = r_count + CW'(1);
        end else if (i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = w_data[0];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_last  = (r_count == CW'(1));

endmodule

`default_nettype wire

>>> hw/rtl/credit_gated_priority_queue_server_top.sv
// Credit-gated strict-priority two-queue server, top level.
// An accepted request's result is registered and appears on the output in the next cycle.
// Throughput: one request per cycle; the queue row, credit compare and subtract all settle
// in that cycle. Input stall rises only while a result waits under output stall.
// Reset (synchronous, active low): queues empty, credit 0, ready flag set, refill amount 10,
// no result pending. Queue cells are not cleared; only written entries are ever read.
`default_nettype none

module credit_gated_priority_queue_server_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SIZE_BITS   = 8,
    parameter int CREDIT_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [cgpqs_pkg::REFILL_BITS-1:0] i_cfg_wr_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [SIZE_BITS-1:0]              i_job_size,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_status,
    output logic                              o_from_low,
    output logic [SIZE_BITS-1:0]              o_served_size,
    output logic [CREDIT_BITS-1:0]            o_credit_left,
    output logic                              o_both_empty
);

    localparam int CMPW = (SIZE_BITS > CREDIT_BITS) ? SIZE_BITS : CREDIT_BITS;
    localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;

    // control state
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [CREDIT_BITS-1:0]            r_credit;
    logic [CREDIT_BITS-1:0]            n_credit;
    logic                              r_ready;
    logic                              n_ready;
    logic [cgpqs_pkg::REFILL_BITS-1:0] r_refill;

    // result payload
    logic [2:0]             r_status;
    logic [2:0]             n_status;
    logic                   r_from_low;
    logic                   n_from_low;
    logic [SIZE_BITS-1:0]   r_served;
    logic [SIZE_BITS-1:0]   n_served;
    logic                   r_both_empty;
    logic                   n_both_empty;

    logic                   w_accept;
    logic                   w_hi_push, w_hi_pop, w_lo_push, w_lo_pop;
    logic [SIZE_BITS-1:0]   w_hi_head, w_lo_head, w_head;
    logic                   w_hi_empty, w_hi_full, w_hi_last;
    logic                   w_lo_empty, w_lo_full, w_lo_last;
    logic [CREDIT_BITS:0]   w_refill_sum;
    logic                   w_fits;
    logic                   w_hi_empty_after, w_lo_empty_after;

    // Stall requests only while the held result is itself stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Strict priority: the high head alone is considered while the high queue holds jobs.
    assign w_head       = w_hi_empty ? w_lo_head : w_hi_head;
    assign w_fits       = r_ready && (CMPW'(w_head) <= CMPW'(r_credit));
    assign w_refill_sum = (CREDIT_BITS + 1)'(r_credit) + (CREDIT_BITS + 1)'(r_refill);

    always_comb begin
        w_hi_push  = 1'b0;
        w_hi_pop   = 1'b0;
        w_lo_push  = 1'b0;
        w_lo_pop   = 1'b0;
        n_credit   = r_credit;
        n_ready    = r_ready;
        n_status   = cgpqs_pkg::ST_NONE;
        n_from_low = 1'b0;
        n_served   = '0;
        unique case (cgpqs_pkg::t_mode'(i_mode))
            cgpqs_pkg::MODE_ENQ_HIGH: begin
                w_hi_push = w_accept && !w_hi_full;
                n_status  = w_hi_full ? cgpqs_pkg::ST_DROPPED : cgpqs_pkg::ST_ENQUEUED;
            end
            cgpqs_pkg::MODE_ENQ_LOW: begin
                w_lo_push = w_accept && !w_lo_full;
                n_status  = w_lo_full ? cgpqs_pkg::ST_DROPPED : cgpqs_pkg::ST_ENQUEUED;
            end
            cgpqs_pkg::MODE_REFILL: begin
                // saturate at the counter's ceiling
                n_credit = w_refill_sum[CREDIT_BITS] ? CREDIT_MAX
                                                     : w_refill_sum[CREDIT_BITS-1:0];
                n_ready  = 1'b1;
                n_status = cgpqs_pkg::ST_REFILLED;
            end
            cgpqs_pkg::MODE_SERVICE: begin
                if (w_hi_empty && w_lo_empty) begin
                    n_status = cgpqs_pkg::ST_NONE;
                end else if (!w_fits) begin
                    n_status = cgpqs_pkg::ST_BLOCKED;
                end else begin
                    w_hi_pop   = w_accept && !w_hi_empty;
                    w_lo_pop   = w_accept && w_hi_empty;
                    n_credit   = r_credit - CREDIT_BITS'(w_head);
                    n_ready    = 1'b0;
                    n_status   = cgpqs_pkg::ST_SERVED;
                    n_from_low = w_hi_empty;
                    n_served   = w_head;
                end
            end
            default: begin
                n_status = cgpqs_pkg::ST_NONE;
            end
        endcase
    end

    // Emptiness after this request's push or pop.
    assign w_hi_empty_after = !w_hi_push && (w_hi_pop ? w_hi_last : w_hi_empty);
    assign w_lo_empty_after = !w_lo_push && (w_lo_pop ? w_lo_last : w_lo_empty);
    assign n_both_empty     = w_hi_empty_after && w_lo_empty_after;

    assign n_out_valid = w_accept || (r_out_valid && i_out_stall);

    cgpqs_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (SIZE_BITS)
    ) u_hi_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_hi_push),
        .i_pop   (w_hi_pop),
        .i_data  (i_job_size),
        .o_head  (w_hi_head),
        .o_empty (w_hi_empty),
        .o_full  (w_hi_full),
        .o_last  (w_hi_last)
    );

    cgpqs_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (SIZE_BITS)
    ) u_lo_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_lo_push),
        .i_pop   (w_lo_pop),
        .i_data  (i_job_size),
        .o_head  (w_lo_head),
        .o_empty (w_lo_empty),
        .o_full  (w_lo_full),
        .o_last  (w_lo_last)
    );

    // Control state: advance credit and ready flag only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_credit    <= '0;
            r_ready     <= 1'b1;
            r_refill    <= cgpqs_pkg::REFILL_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_credit <= n_credit;
                r_ready  <= n_ready;
            end
            if (i_cfg_wr_en) begin
                r_refill <= i_cfg_wr_data;
            end
        end
    end

    // Result register: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_from_low   <= n_from_low;
            r_served     <= n_served;
            r_both_empty <= n_both_empty;
        end
    end

    logic [CREDIT_BITS-1:0] r_credit_out;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_credit_out <= n_credit;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_from_low    = r_from_low;
    assign o_served_size = r_served;
    assign o_credit_left = r_credit_out;
    assign o_both_empty  = r_both_empty;

endmodule

`default_nettype wire

>>> hw/rtl/cgpqs_checker.sv
// Port-level checks for the credit-gated priority queue server, bound to its top level.
// Depends on cgpqs_pkg (status codes).
`default_nettype none

module cgpqs_checker #(
    parameter int SIZE_BITS   = 8,
    parameter int CREDIT_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  logic [2:0]             o_status,
    input  logic                   o_from_low,
    input  logic [SIZE_BITS-1:0]   o_served_size,
    input  logic [CREDIT_BITS-1:0] o_credit_left
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_served_size) && $stable(o_credit_left))
        else $error("stalled result changed");

    // An accepted request always yields a result next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted request produced no result");

    // Stall requests only behind a pending result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stall without pending stalled result");

    // Only a served result carries a size or a queue origin.
    a_served_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != cgpqs_pkg::ST_SERVED)
            |-> (o_served_size == '0) && !o_from_low)
        else $error("size or origin on a non-served result");

endmodule

bind credit_gated_priority_queue_server_top cgpqs_checker #(
    .SIZE_BITS   (SIZE_BITS),
    .CREDIT_BITS (CREDIT_BITS)
) u_cgpqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_from_low    (o_from_low),
    .o_served_size (o_served_size),
    .o_credit_left (o_credit_left)
);

`default_nettype wire

>>> tb/cgpqs_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the credit-gated priority queue server: predicts each result and compares it.
// Depends on cgpqs_pkg for the mode and status codes.

package cgpqs_tb_pkg;

    import cgpqs_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int SIZE_BITS   = 8;
    localparam int CREDIT_BITS = 10;
    localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = {CREDIT_BITS{1'b1}};
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status                status;
        logic                   from_low;
        logic [SIZE_BITS-1:0]   served_size;
        logic [CREDIT_BITS-1:0] credit_left;
        logic                   both_empty;
    } sched_outcome;

    class credit_sched_scoreboard;
        logic [SIZE_BITS-1:0]   high_jobs[$];
        logic [SIZE_BITS-1:0]   low_jobs[$];
        logic [CREDIT_BITS-1:0] credit;
        bit                     ready;
        logic [REFILL_BITS-1:0] refill_amount;
        sched_outcome           awaited_outcomes[$];
        int                     mismatches;
        int                     requests;
        int                     results;
        int                     status_hits[6];
        int                     low_serves;
        int                     saturations;

        function new();
            credit        = '0;
            ready         = 1'b1;
            refill_amount = REFILL_RESET;
            mismatches    = 0;
            requests      = 0;
            results       = 0;
            low_serves    = 0;
            saturations   = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function int pending();
            return awaited_outcomes.size();
        endfunction

        // Advance the queue and credit state by one accepted request, queue its result.
        function void note_request(t_mode mode, logic [SIZE_BITS-1:0] job_size);
            sched_outcome         o;
            logic [CREDIT_BITS:0] sum;
            logic [SIZE_BITS-1:0] head;
            bit                   has_head;
            bit                   use_low;
            o.status      = ST_ENQUEUED;
            o.from_low    = 1'b0;
            o.served_size = '0;
            head          = '0;
            has_head      = 1'b0;
            use_low       = 1'b0;
            case (mode)
                MODE_ENQ_HIGH: begin
                    if (high_jobs.size() >= QUEUE_DEPTH) begin
                        o.status = ST_DROPPED;
                    end else begin
                        high_jobs.push_back(job_size);
                    end
                end
                MODE_ENQ_LOW: begin
                    if (low_jobs.size() >= QUEUE_DEPTH) begin
                        o.status = ST_DROPPED;
                    end else begin
                        low_jobs.push_back(job_size);
                    end
                end
                MODE_REFILL: begin
                    sum = credit + refill_amount;
                    if (sum > CREDIT_MAX) begin
                        credit = CREDIT_MAX;
                        saturations++;
                    end else begin
                        credit = sum[CREDIT_BITS-1:0];
                    end
                    ready    = 1'b1;
                    o.status = ST_REFILLED;
                end
                default: begin
                    // strict priority: the low head is only seen with the high queue empty
                    if (high_jobs.size() != 0) begin
                        head     = high_jobs[0];
                        has_head = 1'b1;
                    end else if (low_jobs.size() != 0) begin
                        head     = low_jobs[0];
                        has_head = 1'b1;
                        use_low  = 1'b1;
                    end
                    if (!has_head) begin
                        o.status = ST_NONE;
                    end else if (!ready || head > credit) begin
                        o.status = ST_BLOCKED;
                    end else begin
                        if (use_low) begin
                            void'(low_jobs.pop_front());
                            low_serves++;
                        end else begin
                            void'(high_jobs.pop_front());
                        end
                        credit        = credit - head;
                        ready         = 1'b0;
                        o.status      = ST_SERVED;
                        o.from_low    = use_low;
                        o.served_size = head;
                    end
                end
            endcase
            o.credit_left = credit;
            o.both_empty  = (high_jobs.size() == 0) && (low_jobs.size() == 0);
            status_hits[o.status]++;
            requests++;
            awaited_outcomes.push_back(o);
        endfunction

        // Compare one accepted result with the oldest queued prediction.
        function void check_result(logic [2:0] status, logic from_low,
                                   logic [SIZE_BITS-1:0] served_size,
                                   logic [CREDIT_BITS-1:0] credit_left, logic both_empty);
            sched_outcome o;
            results++;
            if (awaited_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unrequested result: status=%0d from_low=%0d served=%0d credit=%0d empty=%0d",
                             $time, status, from_low, served_size, credit_left, both_empty);
                return;
            end
            o = awaited_outcomes.pop_front();
            if (status !== o.status || from_low !== o.from_low ||
                served_size !== o.served_size || credit_left !== o.credit_left ||
                both_empty !== o.both_empty) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: result mismatch, expected status=%0d from_low=%0d served=%0d credit=%0d empty=%0d",
                             $time, o.status, o.from_low, o.served_size, o.credit_left,
                             o.both_empty);
                    $display("%0t:                   actual status=%0d from_low=%0d served=%0d credit=%0d empty=%0d",
                             $time, status, from_low, served_size, credit_left, both_empty);
                end
            end
        endfunction
    endclass

endpackage

>>> tb/credit_gated_priority_queue_server_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the credit-gated priority queue server top level.
// Depends on cgpqs_pkg (codes) and cgpqs_tb_pkg (scoreboard); drives directed then random requests.

module credit_gated_priority_queue_server_top_tb;

    import cgpqs_pkg::*;
    import cgpqs_tb_pkg::*;

    localparam int PHASES         = 6;
    localparam int PHASE_REQUESTS = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [REFILL_BITS-1:0] i_cfg_wr_data = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_mode        = MODE_ENQ_HIGH;
    logic [SIZE_BITS-1:0]   i_job_size    = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [2:0]             o_status;
    logic                   o_from_low;
    logic [SIZE_BITS-1:0]   o_served_size;
    logic [CREDIT_BITS-1:0] o_credit_left;
    logic                   o_both_empty;

    credit_sched_scoreboard sb;

    // Percent chance per cycle that the sender idles / the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    credit_gated_priority_queue_server_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SIZE_BITS   (SIZE_BITS),
        .CREDIT_BITS (CREDIT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_job_size    (i_job_size),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_from_low    (o_from_low),
        .o_served_size (o_served_size),
        .o_credit_left (o_credit_left),
        .o_both_empty  (o_both_empty)
    );

    always #5 i_clk = ~i_clk;

    // Receiver side: stall at random with the current phase's rate.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Check every result taken off the output channel. Values sampled right after the
    // edge are the pre-edge ones, so nothing here races with the block's registers.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_from_low, o_served_size, o_credit_left, o_both_empty);
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("credit_gated_priority_queue_server_top_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one request: idle a random number of cycles first, then hold valid and
    // payload until the block takes the request, and note it in the scoreboard.
    task automatic send_request(t_mode mode, logic [SIZE_BITS-1:0] job_size);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_job_size <= job_size;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(mode, job_size);
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Write the refill amount; only called with the block idle.
    task automatic write_refill(logic [REFILL_BITS-1:0] amount);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= amount;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.refill_amount = amount;
    endtask

    initial begin
        int                   phase_idle[PHASES];
        int                   phase_stall[PHASES];
        logic [REFILL_BITS-1:0] phase_refill[PHASES];
        int                   enq_pct;
        int                   high_pct;
        int                   refill_pct;
        int                   roll;
        t_mode                mode;
        logic [SIZE_BITS-1:0] job_size;

        phase_idle   = '{0, 78, 0, 10, 0, 10};
        phase_stall  = '{0, 0, 78, 10, 0, 10};
        phase_refill = '{8'd255, 8'd0, 8'($urandom_range(2, 254)), 8'd1,
                         8'($urandom_range(2, 254)), 8'($urandom_range(2, 254))};
        enq_pct    = 40;
        high_pct   = 50;
        refill_pct = 25;

        sb = new();

        // Hold reset low from time zero, then release it once.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset refill amount of 10.
        send_request(MODE_SERVICE, 8'h00);     // nothing queued, ready flag set
        send_request(MODE_ENQ_HIGH, 8'd7);
        send_request(MODE_ENQ_LOW, 8'd0);
        send_request(MODE_SERVICE, 8'hFF);     // high head larger than zero credit
        send_request(MODE_REFILL, 8'h5A);
        send_request(MODE_SERVICE, 8'h00);     // serve high 7, credit 3
        send_request(MODE_SERVICE, 8'h00);     // blocked: ready flag clear
        send_request(MODE_REFILL, 8'h00);
        send_request(MODE_SERVICE, 8'h00);     // serve low job of size zero
        send_request(MODE_SERVICE, 8'h00);     // both empty, ready clear
        // Fill the high queue with all-ones and all-zeros sizes, then overflow it.
        for (int k = 0; k < QUEUE_DEPTH; k++)
            send_request(MODE_ENQ_HIGH, k[0] ? 8'hFF : 8'h00);
        send_request(MODE_ENQ_HIGH, 8'hA5);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            write_refill(phase_refill[p]);

            // Saturate the credit at the largest refill and serve the high queue's head, a zero-size job.
            if (p == 0) begin
                repeat (5) send_request(MODE_REFILL, 8'h00);
                send_request(MODE_SERVICE, 8'h00);
            end

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Re-roll the request mix every 50 requests so queues fill and empty.
                if (n % 50 == 0) begin
                    enq_pct    = $urandom_range(15, 70);
                    high_pct   = $urandom_range(5, 95);
                    refill_pct = $urandom_range(10, 50);
                end
                roll = $urandom_range(99);
                if (roll < enq_pct)
                    mode = ($urandom_range(99) < high_pct) ? MODE_ENQ_HIGH : MODE_ENQ_LOW;
                else if (roll < enq_pct + (100 - enq_pct) * refill_pct / 100)
                    mode = MODE_REFILL;
                else
                    mode = MODE_SERVICE;
                // Favor small jobs so service keeps flowing at low refill amounts.
                job_size = $urandom_range(1) ? SIZE_BITS'($urandom_range(255))
                                             : SIZE_BITS'($urandom_range(15));
                send_request(mode, job_size);
                if ($urandom_range(199) == 0)
                    drain_results();
            end
            drain_results();
        end

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results over %0d refill settings",
                 sb.requests, sb.results, PHASES + 1);
        $display("enqueued %0d, dropped %0d, refilled %0d (%0d saturating), served %0d (%0d low), blocked %0d, none %0d",
                 sb.status_hits[ST_ENQUEUED], sb.status_hits[ST_DROPPED],
                 sb.status_hits[ST_REFILLED], sb.saturations, sb.status_hits[ST_SERVED],
                 sb.low_serves, sb.status_hits[ST_BLOCKED], sb.status_hits[ST_NONE]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("credit_gated_priority_queue_server_top_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("credit_gated_priority_queue_server_top_tb: done, errors");
        end
        $finish;
    end

endmodule
